// File: src/wialu_pkg.sv
`timescale 1ns / 1ps
package wialu_pkg;

   localparam int WORD_BITS = 128;
   localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_AND = 4'd4,
      OP_OR  = 4'd5,
      OP_XOR = 4'd6,
      OP_NOT = 4'd7,
      OP_SHL = 4'd8,
      OP_SHR = 4'd9,
      OP_ROL = 4'd10,
      OP_ROR = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_NEGB,
      ST_ITER,
      ST_FIX,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [3:0]  mode;
      logic [63:0] operand_a_hi;
      logic [63:0] operand_a_lo;
      logic [63:0] operand_b_hi;
      logic [63:0] operand_b_lo;
      logic [6:0]  shift_amount;
   } req_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
      logic        divide_by_zero;
   } rsp_type;

   // shared adder operation select
   typedef enum logic [1:0] {
      ADD_PLUS,
      ADD_MINUS,
      ADD_NEG
   } add_op_type;

   typedef struct packed {
      add_op_type op;
   } add_ctl_type;

endpackage

// File: src/wialu_adder.sv
`timescale 1ns / 1ps
// shared wide adder: x + y, x - y, or -y
module wialu_adder (
   input  wialu_pkg::add_ctl_type         ctl,
   input  logic [wialu_pkg::WORD_BITS-1:0] x,
   input  logic [wialu_pkg::WORD_BITS-1:0] y,
   output logic [wialu_pkg::WORD_BITS-1:0] sum,
   output logic                            carry
);
   logic [wialu_pkg::WORD_BITS-1:0] xa;
   logic [wialu_pkg::WORD_BITS-1:0] ya;
   logic                            cin;

   // operand conditioning
   always_comb begin
      unique case (ctl.op)
         wialu_pkg::ADD_PLUS: begin
            xa = x; ya = y; cin = 1'b0;
         end
         wialu_pkg::ADD_MINUS: begin
            xa = x; ya = ~y; cin = 1'b1;
         end
         default: begin
            xa = '0; ya = ~y; cin = 1'b1;
         end
      endcase
   end

   assign {carry, sum} = {1'b0, xa} + {1'b0, ya} + {{wialu_pkg::WORD_BITS{1'b0}}, cin};
endmodule

// File: src/wide_integer_alu_128_top.sv
`timescale 1ns / 1ps
// channel | ports                          | payload
// input   | req_valid, req_stall, req_item | wialu_pkg::req_type
// result  | rsp_valid, rsp_stall, rsp_item | wialu_pkg::rsp_type
// add, sub, logic and shift operations pass through the prep state to the result.
// mul runs one shift-and-add step per bit on the shared adder.
// div: operand magnitudes, one restoring step per bit, sign fix; zero divisor skips.
// one item at a time; req_stall is high from accept until the result is taken.
// reset clears the sequencer and the result valid; a stalled result holds.
module wide_integer_alu_128_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  wialu_pkg::req_type  req_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output wialu_pkg::rsp_type  rsp_item
);
   localparam int W = wialu_pkg::WORD_BITS;
   localparam int C = wialu_pkg::CNT_BITS;

   wialu_pkg::state_type state_ff, state_in;
   logic [3:0]          mode_ff, mode_in;
   logic [6:0]          sh_ff, sh_in;
   logic [W-1:0]        a_ff, a_in;
   logic [W-1:0]        b_ff, b_in;
   logic [W-1:0]        acc_ff, acc_in;
   logic [W-1:0]        q_ff, q_in;
   logic [C-1:0]        cnt_ff, cnt_in;
   logic                neg_ff, neg_in;
   wialu_pkg::rsp_type  rsp_ff, rsp_in;

   wialu_pkg::add_ctl_type ctl;
   logic [W-1:0]        ax, ay, sum;
   logic                carry;
   logic [W-1:0]        rem_sh;
   logic                rem_top;
   logic [2*W-1:0]      wide_res;
   logic [W-1:0]        lres;
   logic                accept;
   logic                done_take;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != wialu_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == wialu_pkg::ST_DONE);
   assign rsp_item  = rsp_ff;
   assign done_take = rsp_valid && !rsp_stall;

   assign rem_sh  = {acc_ff[W-2:0], q_ff[W-1]};
   assign rem_top = acc_ff[W-1];

   wialu_adder u_add (.ctl(ctl), .x(ax), .y(ay), .sum(sum), .carry(carry));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wialu_pkg::ST_IDLE: if (accept) state_in = wialu_pkg::ST_PREP;
         wialu_pkg::ST_PREP: begin
            if (mode_ff == wialu_pkg::OP_MUL) begin
               state_in = wialu_pkg::ST_ITER;
            end else if (mode_ff == wialu_pkg::OP_DIV && b_ff != '0) begin
               state_in = wialu_pkg::ST_NEGB;
            end else begin
               state_in = wialu_pkg::ST_DONE;
            end
         end
         wialu_pkg::ST_NEGB: state_in = wialu_pkg::ST_ITER;
         wialu_pkg::ST_ITER: begin
            if (cnt_ff == C'(W - 1)) begin
               state_in = (mode_ff == wialu_pkg::OP_DIV) ? wialu_pkg::ST_FIX
                                                         : wialu_pkg::ST_DONE;
            end
         end
         wialu_pkg::ST_FIX:  state_in = wialu_pkg::ST_DONE;
         wialu_pkg::ST_DONE: if (done_take) state_in = wialu_pkg::ST_IDLE;
         default:            state_in = wialu_pkg::ST_IDLE;
      endcase
   end

   // combinational logic, shift and rotate results
   always_comb begin
      wide_res = {{W{1'b0}}, a_ff} << sh_ff;
      lres = '0;
      unique case (mode_ff)
         wialu_pkg::OP_AND: lres = a_ff & b_ff;
         wialu_pkg::OP_OR:  lres = a_ff | b_ff;
         wialu_pkg::OP_XOR: lres = a_ff ^ b_ff;
         wialu_pkg::OP_NOT: lres = ~a_ff;
         wialu_pkg::OP_SHL: lres = wide_res[W-1:0];
         wialu_pkg::OP_SHR: lres = (32'(sh_ff) >= W) ? '0 : (a_ff >> sh_ff);
         wialu_pkg::OP_ROL: lres = {a_ff[W-2:0], a_ff[W-1]};
         wialu_pkg::OP_ROR: lres = {a_ff[0], a_ff[W-1:1]};
         default:           lres = '0;
      endcase
   end

   // datapath and adder control
   always_comb begin
      mode_in = mode_ff; sh_in = sh_ff; a_in = a_ff; b_in = b_ff;
      acc_in = acc_ff; q_in = q_ff; cnt_in = cnt_ff; neg_in = neg_ff;
      rsp_in = rsp_ff;
      ctl.op = wialu_pkg::ADD_PLUS;
      ax = a_ff; ay = b_ff;
      unique case (state_ff)
         wialu_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in = req_item.mode;
               sh_in   = req_item.shift_amount;
               a_in    = W'({req_item.operand_a_hi, req_item.operand_a_lo});
               b_in    = W'({req_item.operand_b_hi, req_item.operand_b_lo});
               acc_in  = '0;
               cnt_in  = '0;
            end
         end
         wialu_pkg::ST_PREP: begin
            neg_in = a_ff[W-1] ^ b_ff[W-1];
            rsp_in.divide_by_zero = 1'b0;
            unique case (mode_ff)
               wialu_pkg::OP_ADD: begin
                  ctl.op = wialu_pkg::ADD_PLUS;
                  acc_in = sum;
               end
               wialu_pkg::OP_SUB: begin
                  ctl.op = wialu_pkg::ADD_MINUS;
                  acc_in = sum;
               end
               wialu_pkg::OP_MUL: begin
                  acc_in = '0;
               end
               wialu_pkg::OP_DIV: begin
                  // magnitude of a into quotient shifter
                  ctl.op = wialu_pkg::ADD_NEG;
                  ay = a_ff;
                  q_in = a_ff[W-1] ? sum : a_ff;
                  acc_in = '0;
               end
               default: acc_in = lres;
            endcase
            rsp_in.divide_by_zero = (mode_ff == wialu_pkg::OP_DIV) && (b_ff == '0);
            if (mode_ff == wialu_pkg::OP_DIV && b_ff == '0) begin
               acc_in = '0;
            end
         end
         wialu_pkg::ST_NEGB: begin
            // magnitude of b on the shared adder
            ctl.op = wialu_pkg::ADD_NEG;
            ay = b_ff;
            b_in = b_ff[W-1] ? sum : b_ff;
         end
         wialu_pkg::ST_ITER: begin
            cnt_in = cnt_ff + 1'b1;
            if (mode_ff == wialu_pkg::OP_MUL) begin
               ctl.op = wialu_pkg::ADD_PLUS;
               ax = acc_ff; ay = a_ff;
               if (b_ff[0]) acc_in = sum;
               a_in = {a_ff[W-2:0], 1'b0};
               b_in = {1'b0, b_ff[W-1:1]};
            end else begin
               // restoring step
               ctl.op = wialu_pkg::ADD_MINUS;
               ax = rem_sh; ay = b_ff;
               if (rem_top || carry) begin
                  acc_in = sum;
                  q_in = {q_ff[W-2:0], 1'b1};
               end else begin
                  acc_in = rem_sh;
                  q_in = {q_ff[W-2:0], 1'b0};
               end
            end
         end
         wialu_pkg::ST_FIX: begin
            ctl.op = wialu_pkg::ADD_NEG;
            ay = q_ff;
            acc_in = neg_ff ? sum : q_ff;
         end
         default: ;
      endcase
      // result register loads as the done state is entered
      if (state_ff != wialu_pkg::ST_DONE && state_in == wialu_pkg::ST_DONE) begin
         rsp_in.result_hi = 64'(({{(128 - W){1'b0}}, acc_in}) >> 64);
         rsp_in.result_lo = 64'({{(128 - W){1'b0}}, acc_in});
         if (state_ff != wialu_pkg::ST_PREP) rsp_in.divide_by_zero = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wialu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in; sh_ff <= sh_in; a_ff <= a_in; b_ff <= b_in;
      acc_ff <= acc_in; q_ff <= q_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end
endmodule
